// ===== hw/rtl/qlsf_pkg.sv =====
// Package for the quadratic least-squares fit block: payload structs,
// status codes and shared widths. No dependencies.
package qlsf_pkg;

	localparam int SUM_W          = 64;
	localparam int WIDE_W         = 256;
	localparam int COEFF_W        = 48;
	localparam int MAX_POINTS_DEF = 4096;
	localparam int FRAC_BITS_DEF  = 24;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SINGULAR = 2'd1,
		STAT_SAT      = 2'd2,
		STAT_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [11:0] sample_x;
		logic signed [15:0] sample_y;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff_a;
		logic signed [COEFF_W-1:0] coeff_b;
		logic signed [COEFF_W-1:0] coeff_c;
		logic [1:0]                fit_status;
	} fit_t;

endpackage

// ===== hw/rtl/qlsf_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle over the wide word.
// Depends on qlsf_pkg for the word width.
module qlsf_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [qlsf_pkg::WIDE_W-1:0]  dividend,
	input  logic [qlsf_pkg::WIDE_W-1:0]  divisor,
	output logic                         done,
	output logic [qlsf_pkg::WIDE_W-1:0]  quot
);

	localparam int W  = qlsf_pkg::WIDE_W;
	localparam int CW = $clog2(W);

	logic [W:0]    rem_q;
	logic [W-1:0]  dvd_q;
	logic [W-1:0]  dsr_q;
	logic [W-1:0]  quot_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;

	logic [W:0] trial;
	logic       qbit;
	logic [W:0] rem_next;

	always_comb begin
		trial    = {rem_q[W-1:0], dvd_q[W-1]};
		qbit     = (trial >= {1'b0, dsr_q});
		rem_next = qbit ? (trial - {1'b0, dsr_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q  <= '0;
				dvd_q  <= dividend;
				dsr_q  <= divisor;
				quot_q <= '0;
				cnt_q  <= CW'(W - 1);
				run_q  <= 1'b1;
			end else if (run_q) begin
				rem_q  <= rem_next;
				dvd_q  <= {dvd_q[W-2:0], 1'b0};
				quot_q <= {quot_q[W-2:0], qbit};
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/quadratic_least_squares_fit_top.sv =====
// Quadratic least-squares fit, top level. Depends on qlsf_pkg and qlsf_div.
// A point is taken when start is high and busy is low; busy then stays high
// while the power sums and weighted sums are updated, one power of x per
// cycle. On a point marked last the 3x3 normal equations are solved by
// Cramer's rule: four determinants of six triple products each, every product
// built by a shift-add multiplier at one bit per cycle, then three restoring
// divisions. The solve keeps busy high and ends with a one-cycle done strobe
// carrying the fit; the receiver must take it in that cycle.
module quadratic_least_squares_fit_top #(
	parameter int MAX_POINTS = qlsf_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = qlsf_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  qlsf_pkg::point_t point,
	output logic             done,
	output qlsf_pkg::fit_t   fit
);

	localparam int SW = qlsf_pkg::SUM_W;
	localparam int W  = qlsf_pkg::WIDE_W;
	localparam int CO = qlsf_pkg::COEFF_W;
	localparam logic [63:0] POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG = 64'h0000_8000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ACC, ST_INIT, ST_LOAD1, ST_MUL1, ST_LOAD2, ST_MUL2,
		ST_ADD, ST_FIN, ST_DIVB, ST_DIVW, ST_EMIT
	} state_t;

	state_t state_q;

	logic [SW-1:0]      ps_q [5];
	logic [SW-1:0]      ws_q [3];
	logic               ovf_q;
	logic signed [11:0] xs_q;
	logic signed [15:0] ys_q;
	logic               last_q;
	logic signed [47:0] p_q;
	logic [2:0]         k_q;

	logic [1:0]  det_idx_q;
	logic [2:0]  term_q;
	logic [W-1:0] mcand_q;
	logic [SW-1:0] mplr_q;
	logic [5:0]  bit_q;
	logic [W-1:0] prod_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] den_abs_q;
	logic        den_neg_q;
	logic        num_neg_q;
	logic [W-1:0] dvd_q;
	logic        sat_q;
	logic        div_go_q;
	logic        done_q;
	qlsf_pkg::fit_t fit_q;

	logic         div_done;
	logic [W-1:0] div_quot;

	qlsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go_q),
		.dividend (dvd_q),
		.divisor  ({den_abs_q[W-2:0], 1'b0}),
		.done     (div_done),
		.quot     (div_quot)
	);

	// column picked in each row by the six terms of a 3x3 determinant
	function automatic logic [1:0] term_col(input logic [2:0] term, input logic [1:0] row);
		logic [5:0] perm;
		case (term)
			3'd0:    perm = {2'd2, 2'd1, 2'd0};
			3'd1:    perm = {2'd1, 2'd2, 2'd0};
			3'd2:    perm = {2'd2, 2'd0, 2'd1};
			3'd3:    perm = {2'd0, 2'd2, 2'd1};
			3'd4:    perm = {2'd1, 2'd0, 2'd2};
			3'd5:    perm = {2'd0, 2'd1, 2'd2};
			default: perm = '0;
		endcase
		return perm[{row, 1'b0} +: 2];
	endfunction

	function automatic logic term_neg(input logic [2:0] term);
		return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
	endfunction

	// matrix element per row for the current term; determinant 1..3 swaps
	// its column for the weighted sums
	logic [SW-1:0] elem [3];
	always_comb begin
		logic [1:0] col;
		for (int r = 0; r < 3; r++) begin
			col = term_col(term_q, 2'(r));
			if (det_idx_q != 2'd0 && col == det_idx_q - 2'd1)
				elem[r] = ws_q[2'(2 - r)];
			else
				elem[r] = ps_q[3'(4 - r - int'(col))];
		end
	end

	logic signed [39:0] py;
	logic signed [59:0] px;
	always_comb begin
		py = $signed(p_q[23:0]) * ys_q;
		px = p_q * xs_q;
	end

	// saturation of the quotient magnitude
	logic [63:0]   mag, bound, mag_sat;
	logic          over;
	logic [CO-1:0] coeff_val;
	always_comb begin
		mag       = (|div_quot[W-1:64]) ? '1 : div_quot[63:0];
		bound     = num_neg_q ? NEG_MAG : POS_MAX;
		over      = mag > bound;
		mag_sat   = over ? bound : mag;
		coeff_val = num_neg_q ? CO'(64'd0 - mag_sat) : mag_sat[CO-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			for (int i = 0; i < 5; i++) ps_q[i] <= '0;
			for (int i = 0; i < 3; i++) ws_q[i] <= '0;
			ovf_q    <= 1'b0;
			sat_q    <= 1'b0;
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			k_q      <= '0;
			bit_q    <= '0;
			term_q   <= '0;
			det_idx_q <= '0;
		end else begin
			done_q   <= 1'b0;
			div_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						xs_q   <= point.sample_x;
						ys_q   <= point.sample_y;
						last_q <= point.last_point;
						if (ps_q[0] >= 64'(MAX_POINTS)) begin
							ovf_q   <= 1'b1;
							state_q <= point.last_point ? ST_INIT : ST_IDLE;
						end else begin
							p_q     <= 48'sd1;
							k_q     <= '0;
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					ps_q[k_q] <= ps_q[k_q] + SW'(p_q);
					if (k_q < 3'd3)
						ws_q[k_q[1:0]] <= ws_q[k_q[1:0]] + SW'(py);
					p_q <= px[47:0];
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4)
						state_q <= last_q ? ST_INIT : ST_IDLE;
				end
				ST_INIT: begin
					det_idx_q <= '0;
					term_q    <= '0;
					acc_q     <= '0;
					state_q   <= ST_LOAD1;
				end
				ST_LOAD1: begin
					mcand_q <= {{(W-SW){elem[0][SW-1]}}, elem[0]};
					mplr_q  <= elem[1];
					prod_q  <= '0;
					bit_q   <= '0;
					state_q <= ST_MUL1;
				end
				ST_MUL1, ST_MUL2: begin
					// sign bit of the multiplier carries negative weight
					if (mplr_q[0])
						prod_q <= (bit_q == 6'd63) ? prod_q - mcand_q : prod_q + mcand_q;
					mcand_q <= {mcand_q[W-2:0], 1'b0};
					mplr_q  <= {1'b0, mplr_q[SW-1:1]};
					bit_q   <= bit_q + 6'd1;
					if (bit_q == 6'd63)
						state_q <= (state_q == ST_MUL1) ? ST_LOAD2 : ST_ADD;
				end
				ST_LOAD2: begin
					mcand_q <= prod_q;
					mplr_q  <= elem[2];
					prod_q  <= '0;
					bit_q   <= '0;
					state_q <= ST_MUL2;
				end
				ST_ADD: begin
					acc_q <= term_neg(term_q) ? acc_q - prod_q : acc_q + prod_q;
					if (term_q == 3'd5) begin
						state_q <= ST_FIN;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= ST_LOAD1;
					end
				end
				ST_FIN: begin
					term_q <= '0;
					if (det_idx_q == 2'd0) begin
						if (acc_q == '0) begin
							fit_q.coeff_a    <= '0;
							fit_q.coeff_b    <= '0;
							fit_q.coeff_c    <= '0;
							fit_q.fit_status <= qlsf_pkg::STAT_SINGULAR;
							done_q  <= 1'b1;
							for (int i = 0; i < 5; i++) ps_q[i] <= '0;
							for (int i = 0; i < 3; i++) ws_q[i] <= '0;
							ovf_q   <= 1'b0;
							sat_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							den_neg_q <= acc_q[W-1];
							den_abs_q <= acc_q[W-1] ? W'(0) - acc_q : acc_q;
							det_idx_q <= 2'd1;
							acc_q     <= '0;
							state_q   <= ST_LOAD1;
						end
					end else begin
						num_neg_q <= acc_q[W-1] ^ den_neg_q;
						dvd_q     <= acc_q[W-1] ? W'(0) - acc_q : acc_q;
						state_q   <= ST_DIVB;
					end
				end
				ST_DIVB: begin
					// scaled by one extra bit so that adding |den| rounds half away
					dvd_q    <= (dvd_q << (FRAC_BITS + 1)) + den_abs_q;
					div_go_q <= 1'b1;
					state_q  <= ST_DIVW;
				end
				ST_DIVW: begin
					if (div_done) begin
						if (over)
							sat_q <= 1'b1;
						case (det_idx_q)
							2'd1:    fit_q.coeff_a <= coeff_val;
							2'd2:    fit_q.coeff_b <= coeff_val;
							default: fit_q.coeff_c <= coeff_val;
						endcase
						acc_q <= '0;
						if (det_idx_q == 2'd3) begin
							state_q <= ST_EMIT;
						end else begin
							det_idx_q <= det_idx_q + 2'd1;
							state_q   <= ST_LOAD1;
						end
					end
				end
				ST_EMIT: begin
					fit_q.fit_status <= ovf_q ? qlsf_pkg::STAT_OVERFLOW :
						(sat_q ? qlsf_pkg::STAT_SAT : qlsf_pkg::STAT_OK);
					done_q  <= 1'b1;
					for (int i = 0; i < 5; i++) ps_q[i] <= '0;
					for (int i = 0; i < 3; i++) ws_q[i] <= '0;
					ovf_q   <= 1'b0;
					sat_q   <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign fit  = fit_q;

`ifndef NO_ASSERTIONS
	// a fit only comes out of a solve
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a preceding solve");

	// sums are cleared for the next data set once a fit is delivered
	a_cleared_after_fit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ps_q[0] == '0 && !ovf_q))
		else $error("state not cleared after fit");

	// a singular result carries zero coefficients
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fit.fit_status == qlsf_pkg::STAT_SINGULAR) |->
		(fit.coeff_a == '0 && fit.coeff_b == '0 && fit.coeff_c == '0))
		else $error("singular fit with nonzero coefficients");

	// the divider is only started from the solve sequence
	a_div_in_solve: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> $past(state_q == ST_DIVB))
		else $error("divider started outside solve");
`endif

endmodule
